>>> sv/windowed_moving_average_assert.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef WINDOWED_MOVING_AVERAGE_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_ASSERT_SVH
`ifndef SYNTH
`define WMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("windowed_moving_average: same-cycle check failed");
`define WMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("windowed_moving_average: next-cycle check failed");
`else
`define WMA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/wma_pkg.sv
package wma_pkg;

    localparam int WINDOW_LENGTH = 10;

    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 20;
    localparam int HELD_W   = 4;

    localparam int PTR_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
    localparam int SUM_W  = SAMPLE_W + 1 + $clog2(WINDOW_LENGTH);
    localparam int QUO_W  = SUM_W + 4;
    localparam int STEP_W = $clog2(QUO_W);

    localparam int SUM_MAX = 524287;
    localparam int SUM_MIN = -524288;
    localparam int HELD_MAX = 15;

    typedef struct packed {
        logic load_in;
        logic update;
        logic div_init;
        logic div_step;
        logic out_load;
    } wma_cmd_t;

    typedef struct packed {
        logic div_last;
    } wma_status_t;

endpackage

>>> sv/windowed_moving_average.sv
// Moving average over the last ten temperature samples, in tenths of a degree.
// Each accepted beat replaces the oldest sample in the window and yields one
// result beat with the window sum, the number of samples held and the average
// with four fraction bits, truncated toward zero. One sample is worked on at a
// time: an accepted sample passes through the read, prepare, divide and output
// states, and the next sample can be accepted once the result is registered;
// the output state waits while an earlier result has not been taken. The
// restoring divider produces one quotient bit per cycle. The output register
// lets a new sample be accepted while the last result still waits to be taken.
module windowed_moving_average (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [wma_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wma_pkg::OUT_W-1:0]    m_average_q4,
    output logic signed [wma_pkg::OUT_W-1:0]    m_window_sum,
    output logic        [wma_pkg::HELD_W-1:0]   m_samples_held
);
    import wma_pkg::*;

`include "windowed_moving_average_assert.svh"

    wma_cmd_t    cmd;
    wma_status_t status;

    wma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wma_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_sample       (s_sample),
        .m_average_q4   (m_average_q4),
        .m_window_sum   (m_window_sum),
        .m_samples_held (m_samples_held)
    );

    `WMA_ASSERT_SAME(a_out_load_free, aclk, aresetn, cmd.out_load, (!m_valid || m_ready))
    `WMA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, (s_valid && s_ready), !s_ready)
    `WMA_ASSERT_NEXT(a_load_gives_valid, aclk, aresetn, cmd.out_load, m_valid)
    `WMA_ASSERT_SAME(a_held_nonzero, aclk, aresetn, m_valid, (m_samples_held != '0))

endmodule

>>> sv/wma_ctrl.sv
module wma_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  wma_pkg::wma_status_t status,
    output wma_pkg::wma_cmd_t    cmd
);
    import wma_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.update = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> sv/wma_datapath.sv
module wma_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wma_pkg::wma_cmd_t                   cmd,
    output wma_pkg::wma_status_t                status,
    input  logic signed [wma_pkg::SAMPLE_W-1:0] s_sample,
    output logic signed [wma_pkg::OUT_W-1:0]    m_average_q4,
    output logic signed [wma_pkg::OUT_W-1:0]    m_window_sum,
    output logic        [wma_pkg::HELD_W-1:0]   m_samples_held
);
    import wma_pkg::*;

    logic signed [SAMPLE_W-1:0] ring_mem [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0]   ring_valid_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       old_valid_reg;

    logic [PTR_W-1:0]        wptr_reg, wptr_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    logic [CNT_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;

    logic signed [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]           sum_mag;
    logic [CNT_W:0]             shifted;
    logic [CNT_W+1:0]           trial;
    logic [QUO_W-1:0]           quot_signed;
    logic signed [SUM_W+OUT_W-1:0] sum_wide;
    logic signed [OUT_W-1:0]    sum_sat;
    logic [CNT_W+HELD_W-1:0]    fill_wide;
    logic [HELD_W-1:0]          held_sat;

    // The ring itself; the read data is registered on the accepting beat.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            rd_data_reg   <= ring_mem[wptr_reg];
            old_valid_reg <= ring_valid_reg[wptr_reg];
            sample_reg    <= s_sample;
        end
        if (cmd.update) begin
            ring_mem[wptr_reg] <= sample_reg;
        end
    end

    assign old_sample = old_valid_reg ? rd_data_reg : '0;

    always_comb begin
        sum_next  = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
        wptr_next = (wptr_reg == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : wptr_reg + 1'b1;
        fill_next = (fill_reg == CNT_W'(WINDOW_LENGTH)) ? fill_reg : fill_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_valid_reg <= '0;
            wptr_reg       <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
        end else if (cmd.update) begin
            ring_valid_reg[wptr_reg] <= 1'b1;
            wptr_reg                 <= wptr_next;
            fill_reg                 <= fill_next;
            sum_reg                  <= sum_next;
        end
    end

    // Restoring divide of the sum magnitude times sixteen, one quotient bit a cycle.
    assign sum_mag = sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);

    always_comb begin
        shifted   = {rem_reg, quot_reg[QUO_W-1]};
        trial     = {1'b0, shifted} - {2'b00, divisor_reg};
        rem_next  = trial[CNT_W+1] ? shifted[CNT_W-1:0] : trial[CNT_W-1:0];
        quot_next = {quot_reg[QUO_W-2:0], ~trial[CNT_W+1]};
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            neg_reg     <= sum_reg[SUM_W-1];
            quot_reg    <= {sum_mag, 4'b0000};
            rem_reg     <= '0;
            divisor_reg <= fill_reg;
            step_reg    <= '0;
        end else if (cmd.div_step) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg + 1'b1;
        end
    end

    assign status.div_last = (step_reg == STEP_W'(QUO_W - 1));

    always_comb begin
        quot_signed = neg_reg ? (~quot_reg + 1'b1) : quot_reg;
        sum_wide    = (SUM_W + OUT_W)'(sum_reg);
        if (sum_wide > (SUM_W + OUT_W)'(SUM_MAX)) begin
            sum_sat = OUT_W'(SUM_MAX);
        end else if (sum_wide < (SUM_W + OUT_W)'(SUM_MIN)) begin
            sum_sat = OUT_W'(SUM_MIN);
        end else begin
            sum_sat = sum_wide[OUT_W-1:0];
        end
        fill_wide = (CNT_W + HELD_W)'(fill_reg);
        held_sat  = (fill_wide > (CNT_W + HELD_W)'(HELD_MAX)) ? HELD_W'(HELD_MAX)
                                                              : fill_wide[HELD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_average_q4   <= quot_signed[OUT_W-1:0];
            m_window_sum   <= sum_sat;
            m_samples_held <= held_sat;
        end
    end

endmodule

>>> verif/tb_windowed_moving_average.sv
`timescale 1ns / 1ps

module tb_windowed_moving_average;
    import wma_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] average_q4;
        logic signed [OUT_W-1:0] window_sum;
        logic [HELD_W-1:0]       samples_held;
    } window_result_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        bit                         typed;
        logic signed [OUT_W-1:0]    average_q4;
        logic signed [OUT_W-1:0]    window_sum;
        logic [HELD_W-1:0]          samples_held;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam int PHASE_ITEMS   = 385;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 60;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic m_valid;
    logic m_ready;
    logic signed [OUT_W-1:0] m_average_q4;
    logic signed [OUT_W-1:0] m_window_sum;
    logic [HELD_W-1:0] m_samples_held;

    window_result_t expected_averages[$];

    logic signed [SAMPLE_W-1:0] held_samples [WINDOW_LENGTH];
    int next_slot;
    int held_count;
    int exact_sum;

    int idle_pct;
    int stall_pct;
    int hold_request;
    int mismatches;
    int results_checked;
    int samples_sent;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{32767,  1'b1, 524272, 32767, 1},
        '{-32768, 1'b1, -8,     -1,    2},
        '{-1,     1'b1, -10,    -2,    3},
        '{1,      1'b1, -4,     -1,    4},
        '{0,      1'b1, -3,     -1,    5},
        '{32767,  1'b0, 0, 0, 0},
        '{32767,  1'b0, 0, 0, 0},
        '{32767,  1'b0, 0, 0, 0},
        '{32767,  1'b0, 0, 0, 0},
        '{32767,  1'b0, 0, 0, 0},
        '{32767,  1'b0, 0, 0, 0},
        '{32767,  1'b0, 0, 0, 0},
        '{32767,  1'b0, 0, 0, 0},
        '{32767,  1'b0, 0, 0, 0},
        '{32767,  1'b1, 524272, 327670, 10},
        '{-32768, 1'b0, 0, 0, 0},
        '{-32768, 1'b0, 0, 0, 0},
        '{-32768, 1'b0, 0, 0, 0},
        '{-32768, 1'b0, 0, 0, 0},
        '{-32768, 1'b0, 0, 0, 0},
        '{-32768, 1'b0, 0, 0, 0},
        '{-32768, 1'b0, 0, 0, 0},
        '{-32768, 1'b0, 0, 0, 0},
        '{-32768, 1'b0, 0, 0, 0},
        '{-32768, 1'b1, -524288, -327680, 10}
    };

    windowed_moving_average dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average_q4   (m_average_q4),
        .m_window_sum   (m_window_sum),
        .m_samples_held (m_samples_held)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic window_result_t next_window_average(
        input logic signed [SAMPLE_W-1:0] sample
    );
        window_result_t r;
        longint scaled;
        int clipped;
        exact_sum = exact_sum - int'(held_samples[next_slot]) + int'(sample);
        held_samples[next_slot] = sample;
        next_slot = (next_slot == WINDOW_LENGTH - 1) ? 0 : next_slot + 1;
        if (held_count < WINDOW_LENGTH) begin
            held_count++;
        end
        scaled = (longint'(exact_sum) * 16) / held_count;
        clipped = exact_sum;
        if (clipped > SUM_MAX) begin
            clipped = SUM_MAX;
        end
        if (clipped < SUM_MIN) begin
            clipped = SUM_MIN;
        end
        r.average_q4   = scaled[OUT_W-1:0];
        r.window_sum   = clipped[OUT_W-1:0];
        r.samples_held = HELD_W'((held_count > HELD_MAX) ? HELD_MAX : held_count);
        return r;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        window_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_averages.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got avg %0d sum %0d held %0d",
                         $time, m_average_q4, m_window_sum, m_samples_held);
                mismatches++;
            end else begin
                want = expected_averages.pop_front();
                compare_field("average_q4", int'(want.average_q4), int'(m_average_q4));
                compare_field("window_sum", int'(want.window_sum), int'(m_window_sum));
                compare_field("samples_held", int'(want.samples_held), int'(m_samples_held));
                results_checked++;
            end
        end
    end

    // The long hold-off is timed here so that the sender keeps offering beats meanwhile.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    task automatic wait_for_results;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_averages.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        window_result_t predicted;
        window_result_t typed_result;
        logic signed [SAMPLE_W-1:0] value;
        logic signed [SAMPLE_W-1:0] burst_value;
        int burst_left;

        s_valid = 1'b0;
        s_sample = '0;
        aresetn = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 0;
        mismatches = 0;
        results_checked = 0;
        samples_sent = 0;
        burst_left = 0;
        burst_value = '0;
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            held_samples[i] = '0;
        end
        next_slot = 0;
        held_count = 0;
        exact_sum = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].sample);
            predicted = next_window_average(directed_rows[i].sample);
            if (directed_rows[i].typed) begin
                typed_result.average_q4   = directed_rows[i].average_q4;
                typed_result.window_sum   = directed_rows[i].window_sum;
                typed_result.samples_held = directed_rows[i].samples_held;
                expected_averages.push_back(typed_result);
            end else begin
                expected_averages.push_back(predicted);
            end
        end
        wait_for_results();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                3: begin idle_pct = 32; stall_pct = 32; end
                default: begin
                    idle_pct = 0;
                    stall_pct = 0;
                    hold_request = LONG_HOLD;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                if (burst_left == 0 && $urandom_range(0, 39) == 0) begin
                    burst_left = WINDOW_LENGTH + $urandom_range(0, 4);
                    burst_value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                end
                if (burst_left != 0) begin
                    value = burst_value;
                    burst_left--;
                end else begin
                    case ($urandom_range(0, 9))
                        0: value = 16'sh7fff;
                        1: value = 16'sh8000;
                        2, 3: value = SAMPLE_W'(int'($urandom_range(0, 800)) - 400);
                        default: value = SAMPLE_W'($urandom());
                    endcase
                end
                send_sample(value);
                expected_averages.push_back(next_window_average(value));
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_averages.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, expected_averages.size());
            mismatches++;
        end

        $display("Sent %0d sample beats and checked %0d result beats, from full-scale windows",
                 samples_sent, results_checked);
        $display("to random samples, under four idling mixes and one long output hold-off.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/wma_pkg.sv
sv/wma_ctrl.sv
sv/wma_datapath.sv
sv/windowed_moving_average.sv
verif/tb_windowed_moving_average.sv
